// ===== rtl/core/group_descriptor_checksum_unit_defines.svh =====
// Assertion macros shared by the checksum unit.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef GROUP_DESCRIPTOR_CHECKSUM_UNIT_DEFINES_SVH
`define GROUP_DESCRIPTOR_CHECKSUM_UNIT_DEFINES_SVH

// Same-cycle implication.
`define GDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GDC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gdc_pkg.sv =====
package gdc_pkg;

  localparam logic [15:0] CRC16_POLY  = 16'ha001;
  localparam logic [31:0] CRC32C_POLY = 32'h82f63b78;
  localparam logic [15:0] CRC16_INIT  = 16'hffff;
  localparam logic [5:0]  CSUM_OFFSET = 6'd30;
  localparam logic [5:0]  MIN_LENGTH  = 6'd32;

  localparam logic [1:0] MODE_CRC16  = 2'd1;
  localparam logic [1:0] MODE_CRC32C = 2'd2;

  typedef enum logic [1:0] {
    REG_MODE,
    REG_SEED,
    REG_VOL_LO,
    REG_VOL_HI
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_MATCH,
    ST_MISMATCH,
    ST_SHORT,
    ST_DISABLED
  } status_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] seed;
    logic [15:0] prefix;
  } cfg_t;

  // One descriptor word after the group number has been folded in.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [31:0] crc;
  } item_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Folds two bytes, low byte first, into the CRC of the selected mode.
  function automatic logic [31:0] crc_pair(input logic [1:0] mode, input logic [31:0] crc,
                                           input logic [15:0] pair);
    logic [31:0] r;
    case (mode)
      MODE_CRC16: begin
        r = {16'h0000, crc16_byte(crc16_byte(crc[15:0], pair[7:0]), pair[15:8])};
      end
      MODE_CRC32C: begin
        r = crc32c_byte(crc32c_byte(crc, pair[7:0]), pair[15:8]);
      end
      default: begin
        r = 32'h0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/group_descriptor_checksum_unit.sv =====
// Group descriptor checksum unit. Descriptor bytes enter one word per clock
// while in_ready is high, from offset zero, with in_last_byte on the final byte;
// the group number is taken from the first word. A result word is produced through
// the input register, two stages that fold the group number into the CRC two bytes
// at a time, and the result register, which is loaded after one byte update of
// the running CRC. Throughput is one byte per cycle while the result register
// can take each finished result and no prefix walk is in progress. Every
// configuration write starts a walk over the 16-byte volume id, two bytes per
// cycle, and in_ready stays low until that prefix CRC is ready.
module group_descriptor_checksum_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  gdc_pkg::cfg_idx_t cfg_index,
  input  logic [63:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic [31:0]       in_group_number,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_computed_checksum,
  output logic [15:0]       out_stored_checksum,
  output logic [1:0]        out_status
);
  import gdc_pkg::*;

  logic [1:0]  mode_r;
  logic [31:0] seed_r;
  logic [63:0] vol_lo_r;
  logic [63:0] vol_hi_r;

  logic        prefix_busy;
  logic [15:0] prefix;
  logic        adv;
  logic        in_fire;
  logic        s3_valid;
  item_t       s3_item;
  cfg_t        cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 2'd0;
      seed_r   <= 32'h0;
      vol_lo_r <= 64'h0;
      vol_hi_r <= 64'h0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode_r   <= cfg_wdata[1:0];
        REG_SEED:   seed_r   <= cfg_wdata[31:0];
        REG_VOL_LO: vol_lo_r <= cfg_wdata;
        REG_VOL_HI: vol_hi_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign cfg.mode   = mode_r;
  assign cfg.seed   = seed_r;
  assign cfg.prefix = prefix;

  assign in_ready = adv && !prefix_busy;
  assign in_fire  = in_valid && in_ready;

  gdc_prefix u_prefix (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cfg_we),
    .vol_id ({vol_hi_r, vol_lo_r}),
    .busy   (prefix_busy),
    .prefix (prefix)
  );

  gdc_group u_group (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .adv             (adv),
    .in_fire         (in_fire),
    .in_data_byte    (in_data_byte),
    .in_group_number (in_group_number),
    .in_last_byte    (in_last_byte),
    .s3_valid        (s3_valid),
    .s3_item         (s3_item)
  );

  gdc_accum u_accum (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg),
    .s3_valid              (s3_valid),
    .s3_item               (s3_item),
    .adv                   (adv),
    .out_ready             (out_ready),
    .out_valid             (out_valid),
    .out_computed_checksum (out_computed_checksum),
    .out_stored_checksum   (out_stored_checksum),
    .out_status            (out_status)
  );

endmodule

// ===== rtl/core/gdc_prefix.sv =====
module gdc_prefix (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] vol_id,
  output logic         busy,
  output logic [15:0]  prefix
);
  import gdc_pkg::*;

  logic [2:0]  cnt_r;
  logic        busy_r;
  logic [15:0] crc_r;
  logic [15:0] prefix_r;
  logic [15:0] pair;
  logic [15:0] crc_nxt;

  // Two volume id bytes per cycle, until all sixteen are folded in.
  assign pair    = vol_id[{cnt_r, 4'b0000} +: 16];
  assign crc_nxt = crc16_byte(crc16_byte(crc_r, pair[7:0]), pair[15:8]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 3'd0;
      busy_r   <= 1'b0;
      crc_r    <= CRC16_INIT;
      prefix_r <= CRC16_INIT;
    end else if (start) begin
      cnt_r  <= 3'd0;
      busy_r <= 1'b1;
      crc_r  <= CRC16_INIT;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 3'd1;
      crc_r <= crc_nxt;
      if (cnt_r == 3'd7) begin
        busy_r   <= 1'b0;
        prefix_r <= crc_nxt;
      end
    end
  end

  assign busy   = busy_r;
  assign prefix = prefix_r;

endmodule

// ===== rtl/core/gdc_group.sv =====
module gdc_group (
  input  logic          clk,
  input  logic          rst_n,
  input  gdc_pkg::cfg_t cfg,
  input  logic          adv,
  input  logic          in_fire,
  input  logic [7:0]    in_data_byte,
  input  logic [31:0]   in_group_number,
  input  logic          in_last_byte,
  output logic          s3_valid,
  output gdc_pkg::item_t s3_item
);
  import gdc_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_data_r;
  logic [31:0] s1_group_r;
  logic        s1_last_r;

  logic        s2_valid_r;
  logic [7:0]  s2_data_r;
  logic        s2_last_r;
  logic [15:0] s2_group_hi_r;
  logic [31:0] s2_crc_r;

  logic        s3_valid_r;
  item_t       s3_item_r;

  logic [31:0] start_crc;

  // The group number CRC is worked out for every word; only the first word
  // of a descriptor uses it.
  assign start_crc = (cfg.mode == MODE_CRC16) ? {16'h0000, cfg.prefix} : cfg.seed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_fire;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_data_r       <= in_data_byte;
      s1_group_r      <= in_group_number;
      s1_last_r       <= in_last_byte;
      s2_data_r       <= s1_data_r;
      s2_last_r       <= s1_last_r;
      s2_group_hi_r   <= s1_group_r[31:16];
      s2_crc_r        <= crc_pair(cfg.mode, start_crc, s1_group_r[15:0]);
      s3_item_r.data  <= s2_data_r;
      s3_item_r.last  <= s2_last_r;
      s3_item_r.crc   <= crc_pair(cfg.mode, s2_crc_r, s2_group_hi_r);
    end
  end

  assign s3_valid = s3_valid_r;
  assign s3_item  = s3_item_r;

endmodule

// ===== rtl/core/gdc_accum.sv =====
`include "group_descriptor_checksum_unit_defines.svh"

module gdc_accum (
  input  logic           clk,
  input  logic           rst_n,
  input  gdc_pkg::cfg_t  cfg,
  input  logic           s3_valid,
  input  gdc_pkg::item_t s3_item,
  output logic           adv,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [15:0]    out_computed_checksum,
  output logic [15:0]    out_stored_checksum,
  output logic [1:0]     out_status
);
  import gdc_pkg::*;

  logic [5:0]  pos_r;
  logic [31:0] crc_r;
  logic [15:0] cap_r;
  logic        out_valid_r;
  logic [15:0] out_calc_r;
  logic [15:0] out_stored_r;
  status_t     out_status_r;

  logic        fire;
  logic        in_csum;
  logic [31:0] crc_base;
  logic [31:0] crc_nxt;
  logic [15:0] cap_nxt;
  logic [5:0]  pos_inc;
  logic [15:0] res_calc;
  logic [15:0] res_stored;
  status_t     res_status;

  logic        out_match;
  logic        out_blank;
  logic        out_zero;
  logic        sums_equal;

  // Only a last word that finds the result register full has to wait.
  assign adv  = !(s3_valid && s3_item.last && out_valid_r && !out_ready);
  assign fire = s3_valid && adv;

  assign in_csum  = (pos_r == CSUM_OFFSET) || (pos_r == CSUM_OFFSET + 6'd1);
  assign crc_base = (pos_r == 6'd0) ? s3_item.crc : crc_r;
  assign pos_inc  = (pos_r < MIN_LENGTH) ? pos_r + 6'd1 : pos_r;

  // With checksums off the running CRC is left alone; on a first word the
  // group stage already hands over zero.
  always_comb begin
    case (cfg.mode)
      MODE_CRC16: begin
        crc_nxt = in_csum ? crc_base : {16'h0000, crc16_byte(crc_base[15:0], s3_item.data)};
      end
      MODE_CRC32C: begin
        crc_nxt = crc32c_byte(crc_base, in_csum ? 8'h00 : s3_item.data);
      end
      default: begin
        crc_nxt = crc_base;
      end
    endcase
  end

  always_comb begin
    cap_nxt = (pos_r == 6'd0) ? 16'h0000 : cap_r;
    if (pos_r == CSUM_OFFSET) begin
      cap_nxt[7:0] = s3_item.data;
    end else if (pos_r == CSUM_OFFSET + 6'd1) begin
      cap_nxt[15:8] = s3_item.data;
    end
  end

  always_comb begin
    res_calc   = 16'h0000;
    res_stored = 16'h0000;
    if (cfg.mode != MODE_CRC16 && cfg.mode != MODE_CRC32C) begin
      res_status = ST_DISABLED;
    end else if (pos_inc < MIN_LENGTH) begin
      res_status = ST_SHORT;
    end else begin
      res_calc   = crc_nxt[15:0];
      res_stored = cap_nxt;
      if (crc_nxt[15:0] == cap_nxt) begin
        res_status = ST_MATCH;
      end else begin
        res_status = ST_MISMATCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 6'd0;
      crc_r       <= 32'h0;
      cap_r       <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        pos_r <= s3_item.last ? 6'd0 : pos_inc;
        crc_r <= crc_nxt;
        cap_r <= cap_nxt;
      end
      if (fire && s3_item.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s3_item.last) begin
      out_calc_r   <= res_calc;
      out_stored_r <= res_stored;
      out_status_r <= res_status;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_computed_checksum = out_calc_r;
  assign out_stored_checksum   = out_stored_r;
  assign out_status            = out_status_r;

  assign out_match  = (out_status_r == ST_MATCH);
  assign out_blank  = (out_status_r == ST_SHORT) || (out_status_r == ST_DISABLED);
  assign out_zero   = (out_calc_r == 16'h0000) && (out_stored_r == 16'h0000);
  assign sums_equal = (out_calc_r == out_stored_r);

  `GDC_ASSERT_NOW(a_pos_saturates, 1'b1, pos_r <= MIN_LENGTH, "byte position beyond saturation")
  `GDC_ASSERT_NXT(a_pos_clears, fire && s3_item.last, pos_r == 6'd0, "position kept after last word")
  `GDC_ASSERT_NOW(a_match_equal, out_valid_r && out_match, sums_equal, "match on unequal sums")
  `GDC_ASSERT_NOW(a_zero_fields, out_valid_r && out_blank, out_zero, "checksum on blank result")

endmodule
